FILE: hw/rtl/atsd_pkg.sv
// Package of shared constants for the accelerometer tap and shake detector.
`default_nettype none

package atsd_pkg;

  // Width of one accelerometer sample on each axis.
  localparam int SAMPLE_W = 16;

  // Width of each configuration register and of the write data.
  localparam int CFG_DATA_W = 16;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 1;

  // Number of axes held in one window word.
  localparam int AXES = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TAP_THRESHOLD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAKE_THRESHOLD = 1'd1;

  // Register values after reset.
  localparam logic [CFG_DATA_W-1:0] TAP_THRESHOLD_RST   = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] SHAKE_THRESHOLD_RST = 16'd30;

endpackage

`default_nettype wire

FILE: hw/rtl/atsd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module atsd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 10
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/accel_tap_shake_detector.sv
// Top level of the accelerometer tap and shake detector.
//
// The input channel takes one word of three signed 16-bit samples (accel_x,
// accel_y, accel_z) when in_valid is high and in_stall is low. The output
// channel gives one word of two flags per input word, tap_flag and
// shake_flag, moved when out_valid is high and out_stall is low.
// The last WINDOW samples of each axis live in one RAM, read as the word is
// accepted and written back with the new sample in the next cycle; running sums
// are kept in registers. One shared squarer then works through the three sums
// and the shake limit, one square per cycle, with the tap test done alongside.
// A result passes through the update state, the squarer steps and the done
// state before it is presented; no new word is taken until idle is reached.
// The result waits in an output register, so the next word is accepted while
// the receiver stalls; only a second finished result holds the block.
// The configuration port writes tap_threshold (index 0) and shake_threshold
// (index 1) with cfg_wen. Reset (rst, synchronous) empties the window, clears
// the sums and restores the thresholds to 1000 and 30.
`default_nettype none

module accel_tap_shake_detector #(
  parameter int WINDOW = 10
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // Configuration port
  input  wire logic                                    cfg_wen,
  input  wire logic [atsd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [atsd_pkg::CFG_DATA_W-1:0]         cfg_data,
  // Input channel
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [atsd_pkg::SAMPLE_W-1:0]    accel_x,
  input  wire logic signed [atsd_pkg::SAMPLE_W-1:0]    accel_y,
  input  wire logic signed [atsd_pkg::SAMPLE_W-1:0]    accel_z,
  // Output channel
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic                                         tap_flag,
  output logic                                         shake_flag
);

  import atsd_pkg::*;

  // Derived widths.
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int DEV_W  = SUM_W + 1;
  localparam int SN_W   = CFG_DATA_W + CNT_W;
  localparam int OP_W   = SN_W + 1;
  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int WORD_W = AXES * SAMPLE_W;

  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  FILL_FULL  = CNT_W'(WINDOW);
  localparam logic signed [DEV_W-1:0] WIN_DEV = DEV_W'(WINDOW);
  localparam logic [DEV_W-1:0]  WIN_LIM    = DEV_W'(WINDOW);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_SQ   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Squarer steps: three sums, then the shake limit, then the compare.
  localparam logic [2:0] STEP_SUM_X = 3'd0;
  localparam logic [2:0] STEP_SUM_Y = 3'd1;
  localparam logic [2:0] STEP_SUM_Z = 3'd2;
  localparam logic [2:0] STEP_LIMIT = 3'd3;
  localparam logic [2:0] STEP_CMP   = 3'd4;

  logic [1:0]                 state;
  logic [1:0]                 state_next;
  logic [2:0]                 step;
  logic [CFG_DATA_W-1:0]      tap_threshold;
  logic [CFG_DATA_W-1:0]      shake_threshold;
  logic signed [SAMPLE_W-1:0] smp [AXES];
  logic signed [SUM_W-1:0]    sums [AXES];
  logic signed [SUM_W-1:0]    sums_next [AXES];
  logic [CNT_W-1:0]           fill;
  logic [CNT_W-1:0]           fill_next;
  logic [SLOT_W-1:0]          slot;
  logic [SLOT_W-1:0]          slot_next;
  logic [SN_W-1:0]            sn;
  logic signed [OP_W-1:0]     sq_op;
  logic signed [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]           acc;
  logic                       tap_res;
  logic                       shake_res;
  logic                       tap_hit;
  logic                       full_before;
  logic                       in_accept;
  logic                       out_free;
  logic [WORD_W-1:0]          ram_rd_data;
  logic [WORD_W-1:0]          ram_wr_data;
  logic signed [DEV_W-1:0]    dev [AXES];
  logic [DEV_W-1:0]           dev_abs [AXES];
  logic [DEV_W-1:0]           tap_lim;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Window RAM: one word holds the sample of all three axes.
  assign ram_wr_data = {smp[2], smp[1], smp[0]};

  atsd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WINDOW)
  ) u_window_ram (
    .clk     (clk),
    .wr_en   (state == ST_UPD),
    .wr_addr (slot),
    .wr_data (ram_wr_data),
    .rd_en   (in_accept),
    .rd_addr (slot),
    .rd_data (ram_rd_data)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_threshold   <= TAP_THRESHOLD_RST;
      shake_threshold <= SHAKE_THRESHOLD_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_TAP_THRESHOLD:   tap_threshold   <= cfg_data;
        REG_SHAKE_THRESHOLD: shake_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sum, fill and slot update once the oldest sample has been read back.
  always_comb begin
    full_before = (fill == FILL_FULL);
    for (int a = 0; a < AXES; a++) begin
      sums_next[a] = sums[a] + SUM_W'(smp[a]);
      if (full_before) begin
        sums_next[a] = sums_next[a]
                     - SUM_W'($signed(ram_rd_data[a*SAMPLE_W +: SAMPLE_W]));
      end
    end
    fill_next = full_before ? fill : fill + CNT_W'(1);
    slot_next = (slot == SLOT_LAST) ? '0 : slot + SLOT_W'(1);
  end

  // Tap test on the newest sample against the updated sums.
  always_comb begin
    tap_lim = DEV_W'(tap_threshold) * WIN_LIM;
    tap_hit = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      dev[a]     = DEV_W'(smp[a]) * WIN_DEV - DEV_W'(sums[a]);
      dev_abs[a] = dev[a][DEV_W-1] ? DEV_W'(-dev[a]) : DEV_W'(dev[a]);
      if (dev_abs[a] > tap_lim) begin
        tap_hit = 1'b1;
      end
    end
  end

  // Operand of the shared squarer.
  always_comb begin
    case (step)
      STEP_SUM_X: sq_op = OP_W'(sums[0]);
      STEP_SUM_Y: sq_op = OP_W'(sums[1]);
      STEP_SUM_Z: sq_op = OP_W'(sums[2]);
      default:    sq_op = $signed({1'b0, sn});
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_accept) state_next = ST_UPD;
      ST_UPD:  state_next = ST_SQ;
      ST_SQ:   if (step == STEP_CMP) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_SUM_X;
      fill  <= '0;
      slot  <= '0;
      for (int a = 0; a < AXES; a++) begin
        sums[a] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_UPD) begin
        fill <= fill_next;
        slot <= slot_next;
        step <= STEP_SUM_X;
        for (int a = 0; a < AXES; a++) begin
          sums[a] <= sums_next[a];
        end
      end else if (state == ST_SQ) begin
        step <= step + 3'd1;
      end
    end
  end

  // Datapath: sample capture, shake limit, squarer and accumulator.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      smp[0] <= accel_x;
      smp[1] <= accel_y;
      smp[2] <= accel_z;
    end
    if (state == ST_UPD) begin
      sn <= SN_W'(shake_threshold) * SN_W'(fill_next);
    end
    if (state == ST_SQ) begin
      prod <= sq_op * sq_op;
      if (step == STEP_SUM_X) begin
        tap_res <= tap_hit && (fill == FILL_FULL);
      end
      if (step == STEP_SUM_Y) begin
        acc <= ACC_W'(prod);
      end else if (step == STEP_SUM_Z || step == STEP_LIMIT) begin
        acc <= acc + ACC_W'(prod);
      end
      if (step == STEP_CMP) begin
        shake_res <= acc > ACC_W'(prod);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      tap_flag   <= tap_res;
      shake_flag <= shake_res;
    end
  end

  // The window never holds more than WINDOW samples.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("fill count beyond window depth");

  // While the window fills, the ring slot follows the fill count.
  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (fill != FILL_FULL) |-> (CNT_W'(slot) == fill))
    else $error("write slot out of step with fill count");

  // An accepted word is written back to the RAM in the next cycle.
  a_accept_update: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_UPD))
    else $error("accepted word not followed by the RAM update");

  // A new result appears only when the sequencer finishes.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result presented outside the finishing step");

endmodule

`default_nettype wire
